// ===== sv/fplm_pkg.sv =====
// Shared types and constants for the frame pacing and latency monitor.
package fplm_pkg;

  localparam int TIME_BITS  = 48;
  localparam int COUNT_BITS = 32;
  localparam int STAT_BITS  = 32;
  localparam int TOTAL_BITS = 64;
  localparam int KIND_BITS  = 2;
  localparam int STAT_CODE_BITS = 2;
  localparam int CFG_INDEX_BITS = 2;

  localparam logic [STAT_BITS-1:0] STAT_MAX          = '1;
  localparam logic [STAT_BITS-1:0] STALE_LIMIT_RESET = STAT_BITS'(100000);

  localparam logic [KIND_BITS-1:0] KIND_PUBLISH = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_ACK     = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_QUERY   = 2'd2;

  localparam logic [STAT_CODE_BITS-1:0] STATUS_OK       = 2'd0;
  localparam logic [STAT_CODE_BITS-1:0] STATUS_REJECTED = 2'd1;
  localparam logic [STAT_CODE_BITS-1:0] STATUS_IGNORED  = 2'd2;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_STALE_LIMIT     = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_TARGET_INTERVAL = 2'd1;

  typedef struct packed {
    logic [KIND_BITS-1:0] kind;
    logic [TIME_BITS-1:0] timestamp_us;
    logic [STAT_BITS-1:0] ack_id;
  } in_t;

  typedef struct packed {
    logic [STAT_CODE_BITS-1:0] status;
    logic [STAT_BITS-1:0]      latest_frame;
    logic                      stale;
    logic [STAT_BITS-1:0]      age_us;
    logic [STAT_BITS-1:0]      last_interval_us;
    logic [STAT_BITS-1:0]      worst_interval_us;
    logic [STAT_BITS-1:0]      mean_interval_us;
    logic [STAT_BITS-1:0]      late_count;
    logic [STAT_BITS-1:0]      superseded_count;
    logic [STAT_BITS-1:0]      last_latency_us;
    logic [STAT_BITS-1:0]      worst_latency_us;
    logic [STAT_BITS-1:0]      mean_latency_us;
  } out_t;

endpackage

// ===== sv/frame_pacing_latency_monitor_core.sv =====
// Frame pacing and latency monitor: event sequencer with a shared serial divider.
//
// Usage: events (publish, acknowledge, query) arrive on in_valid/in_ready with
// in_data; each gives exactly one result on out_valid/out_ready with out_data.
// Registers stale_limit_us (index 0) and target_interval_us (index 1) are written
// on cfg_valid/cfg_ready; cfg_ready is always high. A zero stale limit is dropped.
// One event at a time: in_ready is high only while the block is idle.
// The result goes from the execute state straight to the output register for a
// rejected publish, an ignored acknowledge, a query or a first publish; when a
// running mean is updated, the 64-step restoring divider runs in between (one
// quotient bit per cycle over the 64-bit total).
// A stalled receiver holds the result in the output register; no new request is
// taken until it is accepted.
// Reset (rst, synchronous) clears all statistics, loads the stale limit with
// 100000 and the target interval with zero; no clearing pass is needed.
module frame_pacing_latency_monitor_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  fplm_pkg::in_t                 in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output fplm_pkg::out_t                out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [fplm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [fplm_pkg::STAT_BITS-1:0]      cfg_data
);
  import fplm_pkg::*;

  localparam int STEP_BITS = $clog2(TOTAL_BITS);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_DIV, S_DONE} state_t;

  state_t state;

  logic [STAT_BITS-1:0]  stale_limit;
  logic [STAT_BITS-1:0]  target_interval;

  in_t                   req;
  logic [TIME_BITS-1:0]  last_time;
  logic [STAT_BITS-1:0]  latest_id;
  logic                  have_frame;
  logic                  frame_seen;
  logic [TOTAL_BITS-1:0] interval_total;
  logic [COUNT_BITS-1:0] published_count;
  logic [TOTAL_BITS-1:0] latency_total;
  logic [COUNT_BITS-1:0] acked_count;
  logic [STAT_BITS-1:0]  interval_last, interval_worst, interval_mean;
  logic [STAT_BITS-1:0]  latency_last, latency_worst, latency_mean;
  logic [STAT_BITS-1:0]  late_total;
  logic [STAT_BITS-1:0]  superseded_total;

  logic [STAT_CODE_BITS-1:0] status;
  logic                      stale;
  logic [STAT_BITS-1:0]      age;

  // divider: num holds dividend, quotient bits shift in at the bottom
  logic [TOTAL_BITS-1:0] div_num;
  logic [COUNT_BITS-1:0] div_den;
  logic [COUNT_BITS-1:0] div_rem;
  logic [STEP_BITS-1:0]  div_step;
  logic                  div_lat;

  // execute-stage arithmetic
  logic [TIME_BITS-1:0]  diff;
  logic                  later;
  logic [STAT_BITS-1:0]  diff_sat;
  logic [TIME_BITS-1:0]  age_full;
  logic                  ts_older;
  logic                  id_match;
  logic [TOTAL_BITS-1:0] interval_total_next;
  logic [TOTAL_BITS-1:0] latency_total_next;
  logic [COUNT_BITS-1:0] acked_count_next;
  logic                  pub_ok;
  logic                  ack_ok;
  logic                  div_start;
  logic [STAT_CODE_BITS-1:0] status_next;
  logic [STAT_BITS-1:0]  age_next;
  logic                  stale_next;

  logic [COUNT_BITS:0]   rem_shift;
  logic [COUNT_BITS:0]   rem_diff;
  logic                  rem_fits;

  always_comb begin
    diff     = req.timestamp_us - last_time;
    later    = req.timestamp_us > last_time;
    ts_older = req.timestamp_us < last_time;
    diff_sat = (diff > TIME_BITS'(STAT_MAX)) ? STAT_MAX : diff[STAT_BITS-1:0];
    age_full = (have_frame && later) ? diff : '0;
    id_match = have_frame && (req.ack_id == latest_id);
    interval_total_next = interval_total + TOTAL_BITS'(diff_sat);
    latency_total_next  = latency_total + TOTAL_BITS'(later ? diff_sat : '0);
    acked_count_next    = acked_count + COUNT_BITS'(1);
    pub_ok = (req.kind == KIND_PUBLISH) && !(have_frame && ts_older);
    ack_ok = (req.kind == KIND_ACK) && id_match;
    status_next = STATUS_OK;
    if (req.kind == KIND_PUBLISH && !pub_ok) status_next = STATUS_REJECTED;
    else if (req.kind == KIND_ACK && !ack_ok) status_next = STATUS_IGNORED;
    // a taken publish moves the frame time to the request, so its age is zero
    age_next   = pub_ok ? '0 : ((age_full > TIME_BITS'(STAT_MAX)) ? STAT_MAX
                                                                 : age_full[STAT_BITS-1:0]);
    stale_next = !pub_ok && (age_full > TIME_BITS'(stale_limit));
    div_start  = (pub_ok && have_frame && published_count != '0) ||
                 (ack_ok && acked_count_next != '0);
    rem_shift = {div_rem, div_num[TOTAL_BITS-1]};
    rem_diff  = rem_shift - {1'b0, div_den};
    rem_fits  = rem_shift >= {1'b0, div_den};
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_DONE);
  assign cfg_ready = 1'b1;

  always_comb begin
    out_data.status            = status;
    out_data.latest_frame      = latest_id;
    out_data.stale             = stale;
    out_data.age_us            = age;
    out_data.last_interval_us  = interval_last;
    out_data.worst_interval_us = interval_worst;
    out_data.mean_interval_us  = interval_mean;
    out_data.late_count        = late_total;
    out_data.superseded_count  = superseded_total;
    out_data.last_latency_us   = latency_last;
    out_data.worst_latency_us  = latency_worst;
    out_data.mean_latency_us   = latency_mean;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      stale_limit      <= STALE_LIMIT_RESET;
      target_interval  <= '0;
      last_time        <= '0;
      latest_id        <= '0;
      have_frame       <= 1'b0;
      frame_seen       <= 1'b1;
      interval_total   <= '0;
      published_count  <= '0;
      latency_total    <= '0;
      acked_count      <= '0;
      interval_last    <= '0;
      interval_worst   <= '0;
      interval_mean    <= '0;
      latency_last     <= '0;
      latency_worst    <= '0;
      latency_mean     <= '0;
      late_total       <= '0;
      superseded_total <= '0;
      div_step         <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_STALE_LIMIT: begin
            if (cfg_data != '0) stale_limit <= cfg_data;
          end
          CFG_TARGET_INTERVAL: target_interval <= cfg_data;
          default: ;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            req   <= in_data;
            state <= S_EXEC;
          end
        end

        S_EXEC: begin
          status   <= status_next;
          age      <= age_next;
          stale    <= stale_next;
          div_step <= '0;
          div_rem  <= '0;
          state    <= div_start ? S_DIV : S_DONE;
          case (req.kind)
            KIND_PUBLISH: begin
              if (pub_ok) begin
                if (have_frame) begin
                  interval_last  <= diff_sat;
                  if (diff_sat > interval_worst) interval_worst <= diff_sat;
                  interval_total <= interval_total_next;
                  if (target_interval != '0 && diff_sat > target_interval)
                    late_total <= late_total + STAT_BITS'(1);
                  // mean over intervals: count before this publish
                  if (published_count == '0) begin
                    interval_mean <= '0;
                  end else begin
                    div_num <= interval_total_next;
                    div_den <= published_count;
                    div_lat <= 1'b0;
                  end
                end
                if (!frame_seen) superseded_total <= superseded_total + STAT_BITS'(1);
                latest_id       <= latest_id + STAT_BITS'(1);
                last_time       <= req.timestamp_us;
                have_frame      <= 1'b1;
                frame_seen      <= 1'b0;
                published_count <= published_count + COUNT_BITS'(1);
              end
            end
            KIND_ACK: begin
              if (ack_ok) begin
                frame_seen    <= 1'b1;
                latency_last  <= later ? diff_sat : '0;
                if ((later ? diff_sat : '0) > latency_worst)
                  latency_worst <= later ? diff_sat : '0;
                acked_count   <= acked_count_next;
                latency_total <= latency_total_next;
                if (acked_count_next == '0) begin
                  latency_mean <= '0;
                end else begin
                  div_num <= latency_total_next;
                  div_den <= acked_count_next;
                  div_lat <= 1'b1;
                end
              end
            end
            default: ;
          endcase
        end

        S_DIV: begin
          // one restoring step per cycle
          div_rem  <= rem_fits ? rem_diff[COUNT_BITS-1:0] : rem_shift[COUNT_BITS-1:0];
          div_num  <= {div_num[TOTAL_BITS-2:0], rem_fits};
          div_step <= div_step + STEP_BITS'(1);
          if (div_step == '1) begin
            if (div_lat) latency_mean <= {div_num[STAT_BITS-2:0], rem_fits};
            else         interval_mean <= {div_num[STAT_BITS-2:0], rem_fits};
            state <= S_DONE;
          end
        end

        S_DONE: begin
          if (out_ready) state <= S_IDLE;
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the frame pacing and latency monitor core.
module tb_top;
  import fplm_pkg::*;

  localparam int CLK_HALF       = 6;
  localparam int RESET_CYCLES   = 7;
  localparam int IDLE_PCT       = 37;
  localparam int RANDOM_EVENTS  = 450;
  localparam int HOLD_CYCLES    = 400;
  localparam int TAIL_CYCLES    = 80;
  localparam int TIMEOUT_CYCLES = 600000;
  localparam int REPORT_LIMIT   = 10;

  localparam logic [KIND_BITS-1:0]      KIND_SPARE   = 2'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_HI = 2'd3;

  localparam logic [TIME_BITS-1:0] TS_MAX  = '1;
  localparam logic [TIME_BITS-1:0] TS_JUMP = 48'd1007 + 48'h1_0000_0000;
  localparam logic [TIME_BITS-1:0] TS_LONG = TS_JUMP + 48'hFFFF_FFFF;
  localparam logic [TIME_BITS-1:0] TS_NEXT = TS_LONG + 48'd3;

  typedef struct {
    bit                        is_cfg;
    in_t                       ev;
    logic [CFG_INDEX_BITS-1:0] cidx;
    logic [STAT_BITS-1:0]      cdata;
    bit                        pinned;
    logic [STAT_CODE_BITS-1:0] st;
    logic [STAT_BITS-1:0]      fid;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [STAT_BITS-1:0]      cfg_data;

  // hand-typed status and id travelling alongside a directed request
  logic                      row_pinned;
  logic [STAT_CODE_BITS-1:0] row_status;
  logic [STAT_BITS-1:0]      row_id;

  bit          no_gaps;
  int unsigned rx_hold_len;

  // predictor state
  logic [STAT_BITS-1:0]  stale_us, target_us;
  logic [TIME_BITS-1:0]  frame_ts;
  logic [STAT_BITS-1:0]  cur_id;
  bit                    have_frame, frame_acked;
  logic [TOTAL_BITS-1:0] iv_sum, lat_sum;
  logic [COUNT_BITS-1:0] pub_cnt, ack_cnt;
  logic [STAT_BITS-1:0]  iv_last, iv_worst, iv_mean;
  logic [STAT_BITS-1:0]  lat_last, lat_worst, lat_mean;
  logic [STAT_BITS-1:0]  late_cnt, sup_cnt;

  out_t pending_results[$];
  logic [TIME_BITS-1:0] wall_us;

  int unsigned mismatches, n_results, n_cfg;
  int unsigned n_pub_ok, n_pub_rej, n_ack_ok, n_ack_ign, n_query;

  frame_pacing_latency_monitor_core u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  function automatic logic [STAT_BITS-1:0] sat_us(logic [TIME_BITS-1:0] d);
    if (d > TIME_BITS'(STAT_MAX)) return STAT_MAX;
    return d[STAT_BITS-1:0];
  endfunction

  function automatic logic [STAT_BITS-1:0] mean_us(logic [TOTAL_BITS-1:0] sum,
                                                    logic [COUNT_BITS-1:0] cnt);
    logic [TOTAL_BITS-1:0] q;
    if (cnt == 0) return '0;
    q = sum / TOTAL_BITS'(cnt);
    return q[STAT_BITS-1:0];
  endfunction

  function automatic logic [TIME_BITS-1:0] age_at(logic [TIME_BITS-1:0] ts);
    if (!have_frame || ts <= frame_ts) return '0;
    return ts - frame_ts;
  endfunction

  function automatic void pacing_reset();
    stale_us    = STALE_LIMIT_RESET;
    target_us   = '0;
    frame_ts    = '0;
    cur_id      = '0;
    have_frame  = 1'b0;
    frame_acked = 1'b1;
    iv_sum      = '0;
    lat_sum     = '0;
    pub_cnt     = '0;
    ack_cnt     = '0;
    iv_last     = '0;
    iv_worst    = '0;
    iv_mean     = '0;
    lat_last    = '0;
    lat_worst   = '0;
    lat_mean    = '0;
    late_cnt    = '0;
    sup_cnt     = '0;
  endfunction

  function automatic void pacing_config(logic [CFG_INDEX_BITS-1:0] idx,
                                        logic [STAT_BITS-1:0] val);
    if (idx == CFG_STALE_LIMIT) begin
      if (val != 0) stale_us = val;
    end else if (idx == CFG_TARGET_INTERVAL) begin
      target_us = val;
    end
  endfunction

  // advance the pacing state by one request and give the result it produces
  function automatic out_t pacing_predict(in_t ev);
    logic [STAT_CODE_BITS-1:0] st;
    logic [STAT_BITS-1:0]      gap, lat;
    logic [TIME_BITS-1:0]      span;
    out_t                      r;
    st = STATUS_OK;
    if (ev.kind == KIND_PUBLISH) begin
      if (have_frame && ev.timestamp_us < frame_ts) begin
        st = STATUS_REJECTED;
      end else begin
        if (have_frame) begin
          gap = sat_us(ev.timestamp_us - frame_ts);
          iv_last = gap;
          if (gap > iv_worst) iv_worst = gap;
          iv_sum = iv_sum + TOTAL_BITS'(gap);
          // mean over intervals: count taken before this frame is added
          iv_mean = mean_us(iv_sum, pub_cnt);
          if (target_us != 0 && gap > target_us) late_cnt = late_cnt + 1'b1;
        end
        if (!frame_acked) sup_cnt = sup_cnt + 1'b1;
        cur_id      = cur_id + 1'b1;
        frame_ts    = ev.timestamp_us;
        have_frame  = 1'b1;
        frame_acked = 1'b0;
        pub_cnt     = pub_cnt + 1'b1;
      end
    end else if (ev.kind == KIND_ACK) begin
      if (!have_frame || ev.ack_id != cur_id) begin
        st = STATUS_IGNORED;
      end else begin
        lat = sat_us(age_at(ev.timestamp_us));
        frame_acked = 1'b1;
        lat_last = lat;
        if (lat > lat_worst) lat_worst = lat;
        ack_cnt  = ack_cnt + 1'b1;
        lat_sum  = lat_sum + TOTAL_BITS'(lat);
        lat_mean = mean_us(lat_sum, ack_cnt);
      end
    end
    span = age_at(ev.timestamp_us);
    r.status            = st;
    r.latest_frame      = cur_id;
    r.stale             = have_frame && (span > TIME_BITS'(stale_us));
    r.age_us            = sat_us(span);
    r.last_interval_us  = iv_last;
    r.worst_interval_us = iv_worst;
    r.mean_interval_us  = iv_mean;
    r.late_count        = late_cnt;
    r.superseded_count  = sup_cnt;
    r.last_latency_us   = lat_last;
    r.worst_latency_us  = lat_worst;
    r.mean_latency_us   = lat_mean;
    return r;
  endfunction

  task automatic note_mismatch(string what, logic [63:0] want, logic [63:0] got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT)
      $display("mismatch on %s: expected 0x%0h, got 0x%0h", what, want, got);
  endtask

  task automatic compare_result(out_t want, out_t got);
    if (want.status !== got.status)
      note_mismatch("status", 64'(want.status), 64'(got.status));
    if (want.latest_frame !== got.latest_frame)
      note_mismatch("latest_frame", 64'(want.latest_frame), 64'(got.latest_frame));
    if (want.stale !== got.stale)
      note_mismatch("stale", 64'(want.stale), 64'(got.stale));
    if (want.age_us !== got.age_us)
      note_mismatch("age_us", 64'(want.age_us), 64'(got.age_us));
    if (want.last_interval_us !== got.last_interval_us)
      note_mismatch("last_interval_us", 64'(want.last_interval_us),
                    64'(got.last_interval_us));
    if (want.worst_interval_us !== got.worst_interval_us)
      note_mismatch("worst_interval_us", 64'(want.worst_interval_us),
                    64'(got.worst_interval_us));
    if (want.mean_interval_us !== got.mean_interval_us)
      note_mismatch("mean_interval_us", 64'(want.mean_interval_us),
                    64'(got.mean_interval_us));
    if (want.late_count !== got.late_count)
      note_mismatch("late_count", 64'(want.late_count), 64'(got.late_count));
    if (want.superseded_count !== got.superseded_count)
      note_mismatch("superseded_count", 64'(want.superseded_count),
                    64'(got.superseded_count));
    if (want.last_latency_us !== got.last_latency_us)
      note_mismatch("last_latency_us", 64'(want.last_latency_us),
                    64'(got.last_latency_us));
    if (want.worst_latency_us !== got.worst_latency_us)
      note_mismatch("worst_latency_us", 64'(want.worst_latency_us),
                    64'(got.worst_latency_us));
    if (want.mean_latency_us !== got.mean_latency_us)
      note_mismatch("mean_latency_us", 64'(want.mean_latency_us),
                    64'(got.mean_latency_us));
  endtask

  // sample every handshake at the rising edge
  always @(posedge clk) begin : scoreboard
    out_t want;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        pacing_config(cfg_index, cfg_data);
        n_cfg++;
      end
      if (in_valid && in_ready) begin
        want = pacing_predict(in_data);
        if (in_data.kind == KIND_PUBLISH) begin
          if (want.status == STATUS_OK) n_pub_ok++;
          else n_pub_rej++;
        end else if (in_data.kind == KIND_ACK) begin
          if (want.status == STATUS_OK) n_ack_ok++;
          else n_ack_ign++;
        end else begin
          n_query++;
        end
        if (row_pinned) begin
          want.status       = row_status;
          want.latest_frame = row_id;
        end
        pending_results.push_back(want);
      end
      if (out_valid && out_ready) begin
        n_results++;
        if (pending_results.size() == 0) begin
          note_mismatch("result with no request pending", '0, 64'(out_data.latest_frame));
        end else begin
          compare_result(pending_results.pop_front(), out_data);
        end
      end
    end
  end

  // receiver: random back-pressure, plus one long hold-off on request
  initial begin : receiver
    int unsigned hold;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_len != 0) begin
        hold = rx_hold_len;
        rx_hold_len = 0;
        out_ready <= 1'b0;
        repeat (hold) @(negedge clk);
      end else begin
        out_ready <= no_gaps || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_event(in_t ev, bit pin, logic [STAT_CODE_BITS-1:0] st,
                            logic [STAT_BITS-1:0] fid);
    cfg_valid <= 1'b0;
    if (!no_gaps) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid   <= 1'b1;
    in_data    <= ev;
    row_pinned <= pin;
    row_status <= st;
    row_id     <= fid;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [STAT_BITS-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // hold off new requests until every result is back
  task automatic drain_block();
    in_valid  <= 1'b0;
    cfg_valid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
  endtask

  function automatic plan_row_t mk_ev(logic [KIND_BITS-1:0] kind, logic [TIME_BITS-1:0] ts,
                                      logic [STAT_BITS-1:0] id, bit pin,
                                      logic [STAT_CODE_BITS-1:0] st,
                                      logic [STAT_BITS-1:0] fid);
    plan_row_t r;
    r.is_cfg          = 1'b0;
    r.ev.kind         = kind;
    r.ev.timestamp_us = ts;
    r.ev.ack_id       = id;
    r.cidx            = '0;
    r.cdata           = '0;
    r.pinned          = pin;
    r.st              = st;
    r.fid             = fid;
    return r;
  endfunction

  function automatic plan_row_t mk_cfg(logic [CFG_INDEX_BITS-1:0] idx,
                                       logic [STAT_BITS-1:0] val);
    plan_row_t r;
    r        = mk_ev(KIND_QUERY, '0, '0, 1'b0, STATUS_OK, '0);
    r.is_cfg = 1'b1;
    r.cidx   = idx;
    r.cdata  = val;
    return r;
  endfunction

  function automatic in_t random_request();
    in_t         ev;
    int unsigned pick, sel;
    logic [TIME_BITS-1:0] d;
    pick = $urandom_range(0, 99);
    sel  = $urandom_range(0, 99);
    ev.ack_id       = $urandom;
    ev.timestamp_us = wall_us + TIME_BITS'($urandom_range(0, 6000));
    if (pick < 45) begin
      ev.kind = KIND_PUBLISH;
      if (sel < 8 && have_frame && frame_ts > 48'd500) begin
        ev.timestamp_us = frame_ts - TIME_BITS'($urandom_range(1, 500));
      end else begin
        if (sel < 14) d = '0;
        else if (sel < 19) d = 48'h1_0000_0000 + TIME_BITS'($urandom);
        else if (sel < 30) d = TIME_BITS'($urandom_range(0, 200000));
        else d = TIME_BITS'($urandom_range(0, 4000));
        wall_us = wall_us + d;
        ev.timestamp_us = wall_us;
      end
    end else if (pick < 75) begin
      ev.kind = KIND_ACK;
      if (sel < 65) ev.ack_id = cur_id;
      else if (sel < 80) ev.ack_id = cur_id + STAT_BITS'($urandom_range(0, 2)) - 1'b1;
      if ($urandom_range(0, 9) == 0) ev.timestamp_us = frame_ts - TIME_BITS'($urandom_range(0, 50));
    end else begin
      ev.kind = ($urandom_range(0, 9) == 0) ? KIND_SPARE : KIND_QUERY;
      if (sel < 10) ev.timestamp_us = TIME_BITS'({$urandom, $urandom});
      else ev.timestamp_us = wall_us + TIME_BITS'($urandom_range(0, 150000));
    end
    return ev;
  endfunction

  initial begin : stimulus
    plan_row_t   plan[$];
    plan_row_t   r;
    int unsigned i, sel;
    rst         = 1'b1;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    row_pinned  = 1'b0;
    row_status  = '0;
    row_id      = '0;
    no_gaps     = 1'b0;
    rx_hold_len = 0;
    mismatches  = 0;
    n_results   = 0;
    n_cfg       = 0;
    n_pub_ok    = 0;
    n_pub_rej   = 0;
    n_ack_ok    = 0;
    n_ack_ign   = 0;
    n_query     = 0;
    wall_us     = TS_NEXT + 48'd10;
    pacing_reset();

    // reset state, first publish, ordering and acknowledge rules
    plan.push_back(mk_ev(KIND_QUERY,   48'd0,    32'd0, 1, STATUS_OK,       32'd0));
    plan.push_back(mk_ev(KIND_ACK,     48'd0,    32'd0, 1, STATUS_IGNORED,  32'd0));
    plan.push_back(mk_ev(KIND_PUBLISH, 48'd1000, 32'd0, 1, STATUS_OK,       32'd1));
    plan.push_back(mk_ev(KIND_PUBLISH, 48'd500,  32'd0, 1, STATUS_REJECTED, 32'd1));
    plan.push_back(mk_ev(KIND_ACK,     48'd1200, 32'd5, 1, STATUS_IGNORED,  32'd1));
    plan.push_back(mk_ev(KIND_ACK,     48'd1500, 32'd1, 1, STATUS_OK,       32'd1));
    plan.push_back(mk_ev(KIND_ACK,     48'd2000, 32'd1, 1, STATUS_OK,       32'd1));
    plan.push_back(mk_ev(KIND_PUBLISH, 48'd1000, 32'd0, 1, STATUS_OK,       32'd2));
    plan.push_back(mk_ev(KIND_QUERY,   48'd101001, 32'd0, 0, STATUS_OK,     32'd0));
    plan.push_back(mk_ev(KIND_QUERY,   48'd101000, 32'd0, 0, STATUS_OK,     32'd0));
    // a zero stale limit must be dropped
    plan.push_back(mk_cfg(CFG_STALE_LIMIT, 32'd0));
    plan.push_back(mk_cfg(CFG_TARGET_INTERVAL, 32'd1));
    plan.push_back(mk_ev(KIND_PUBLISH, 48'd1002, 32'd0, 1, STATUS_OK,       32'd3));
    plan.push_back(mk_ev(KIND_PUBLISH, TS_JUMP,  32'd0, 1, STATUS_OK,       32'd4));
    plan.push_back(mk_ev(KIND_SPARE,   TS_MAX,   32'd0, 0, STATUS_OK,       32'd0));
    plan.push_back(mk_ev(KIND_ACK,     TS_MAX,   32'd4, 1, STATUS_OK,       32'd4));
    plan.push_back(mk_ev(KIND_ACK,     48'd0,    32'd4, 1, STATUS_OK,       32'd4));
    plan.push_back(mk_cfg(CFG_STALE_LIMIT, 32'd1));
    plan.push_back(mk_cfg(CFG_TARGET_INTERVAL, 32'hFFFF_FFFF));
    plan.push_back(mk_cfg(CFG_SPARE_LO, 32'd123));
    plan.push_back(mk_cfg(CFG_SPARE_HI, 32'hA5A5_5A5A));
    plan.push_back(mk_ev(KIND_QUERY,   TS_JUMP + 48'd2, 32'd0, 0, STATUS_OK, 32'd0));
    plan.push_back(mk_ev(KIND_QUERY,   TS_JUMP + 48'd1, 32'd0, 0, STATUS_OK, 32'd0));
    plan.push_back(mk_ev(KIND_ACK,     48'd0, 32'hFFFF_FFFF, 1, STATUS_IGNORED, 32'd4));
    plan.push_back(mk_ev(KIND_PUBLISH, TS_LONG,  32'd0, 1, STATUS_OK,       32'd5));
    plan.push_back(mk_ev(KIND_PUBLISH, TS_NEXT,  32'd0, 1, STATUS_OK,       32'd6));
    plan.push_back(mk_cfg(CFG_STALE_LIMIT, 32'hFFFF_FFFF));
    plan.push_back(mk_cfg(CFG_TARGET_INTERVAL, 32'd256));
    plan.push_back(mk_ev(KIND_QUERY,   TS_MAX,   32'd0, 0, STATUS_OK,       32'd0));

    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    foreach (plan[k]) begin
      r = plan[k];
      if (r.is_cfg) begin
        drain_block();
        write_reg(r.cidx, r.cdata);
      end else begin
        send_event(r.ev, r.pinned, r.st, r.fid);
      end
    end

    for (i = 0; i < RANDOM_EVENTS; i++) begin
      no_gaps = (i >= 300 && i < 370);
      if (i == 150) drain_block();
      if (i == 200) rx_hold_len = HOLD_CYCLES;
      if (i % 110 == 55) begin
        drain_block();
        sel = $urandom_range(0, 3);
        write_reg(CFG_STALE_LIMIT, (sel == 0) ? 32'd1 : (sel == 1) ? $urandom :
                                   STAT_BITS'($urandom_range(1, 150000)));
        sel = $urandom_range(0, 3);
        write_reg(CFG_TARGET_INTERVAL, (sel == 0) ? 32'd0 : (sel == 1) ? $urandom :
                                       STAT_BITS'($urandom_range(1, 3000)));
        if (sel == 3) write_reg(($urandom_range(0, 1) != 0) ? CFG_SPARE_HI : CFG_SPARE_LO,
                                $urandom);
      end
      send_event(random_request(), 1'b0, STATUS_OK, '0);
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("covered %0d results: %0d publishes taken, %0d out of order, %0d acks counted,",
             n_results, n_pub_ok, n_pub_rej, n_ack_ok);
    $display("%0d acks ignored, %0d queries, %0d register writes, %0d mismatching fields",
             n_ack_ign, n_query, n_cfg, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("frame_pacing_latency_monitor_core regression: pass");
    end else begin
      $display("frame_pacing_latency_monitor_core regression: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_CYCLES * 2 * CLK_HALF);
    $display("timeout waiting for results");
    $display("frame_pacing_latency_monitor_core regression: fail");
    $finish;
  end

endmodule
